// File: design/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg: shared types and constants of the escape-time pixel
// Fixed-point widths, escape limit, command and status groups that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package mep_pkg;

  // Coordinate format: signed, FRAC_BITS fraction bits
  localparam int COORD_W   = 64;
  localparam int FRAC_BITS = 56;
  localparam int HALF_W    = COORD_W / 2;
  localparam int ACC_W     = 2 * COORD_W;
  // Width of a scaled square: full product with the fraction bits dropped
  localparam int SQ_W      = ACC_W - FRAC_BITS;

  // Cycle detection: save z every PERIOD_SPAN + 1 iterations
  localparam int PERIOD_SPAN = 20;
  localparam int PERIOD_W    = $clog2(PERIOD_SPAN + 1);

  // Iteration count and limit register
  localparam int                ITER_W         = 16;
  localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(1024);

  // Result pixel
  localparam int                 PIXEL_W      = 8;
  localparam logic [PIXEL_W-1:0] PIXEL_INSIDE = PIXEL_W'(128);

  // Escape when |z|^2 exceeds the squared radius
  localparam int                ESC_RADIUS_SQ = 4;
  localparam logic [SQ_W:0]     ESC_LIMIT     = (SQ_W + 1)'(ESC_RADIUS_SQ) << FRAC_BITS;

  // Shared multiplier: four partial products per 64x64 product
  localparam int MUL_PARTS = 4;
  localparam int PP_IDX_W  = $clog2(MUL_PARTS);

  // Operand pair for the shared multiplier
  typedef enum logic [1:0] {
    SRC_RE = 2'd0,   // |z_re| * |z_re|
    SRC_IM = 2'd1,   // |z_im| * |z_im|
    SRC_X  = 2'd2    // |z_re| * |z_im|
  } mul_src_t;

  // Controller to datapath
  typedef struct packed {
    logic                load;       // take a new point, clear z and counters
    logic                mag_load;   // latch magnitudes of z
    mul_src_t            src;
    logic [PP_IDX_W-1:0] pp_idx;     // partial product to form
    logic                acc_clr;
    logic                acc_add;    // add the registered partial product
    logic                save_re2;
    logic                save_im2;
    logic                negate;     // sign fix of the cross product
    logic                advance;    // commit the new z
    logic                out_load;   // load the result register
    logic                res_inside; // result is the inside code
  } mep_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic escape;
    logic match;
    logic at_limit;
  } mep_status_t;

endpackage

// File: design/mep_if.sv
// ----------------------------------------------------------------------------
// mep_if: valid/ready channels of the escape-time pixel
// Point channel carries c; pixel channel carries the result value.
// ----------------------------------------------------------------------------
interface mep_in_if;
  import mep_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] c_re;
  logic signed [COORD_W-1:0] c_im;

  modport source (output valid, output c_re, output c_im, input ready);
  modport sink   (input valid, input c_re, input c_im, output ready);
endinterface

interface mep_out_if;
  import mep_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// File: design/mep_dpath.sv
// ----------------------------------------------------------------------------
// mep_dpath: escape-time datapath
// Holds c, z, saved z and counters; one shared 32x32 multiplier builds the
// three 64x64 products from registered partial products.
// ----------------------------------------------------------------------------
module mep_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [mep_pkg::COORD_W-1:0] c_re,
  input  logic signed [mep_pkg::COORD_W-1:0] c_im,
  input  logic                               cfg_wr_en,
  input  logic        [mep_pkg::ITER_W-1:0]  cfg_wr_data,
  input  mep_pkg::mep_cmd_t                  cmd,
  output mep_pkg::mep_status_t               status,
  output logic        [mep_pkg::PIXEL_W-1:0] pixel_value
);
  import mep_pkg::*;

  localparam logic signed [COORD_W-1:0] S_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] S_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic        [ITER_W-1:0]   max_iterations;
  logic signed [COORD_W-1:0]  cr, ci, zr, zi, sr, si;
  logic        [COORD_W-1:0]  mag_re, mag_im;
  logic        [ITER_W-1:0]   k;
  logic        [PERIOD_W-1:0] period;
  logic        [2*HALF_W-1:0] pp;
  logic        [PP_IDX_W-1:0] pp_idx_q;
  logic        [ACC_W-1:0]    acc;
  logic        [SQ_W-1:0]     re2;
  logic        [COORD_W-1:0]  im2;
  logic        [COORD_W-1:0]  diff;

  logic        [COORD_W-1:0]  op_a, op_b;
  logic        [HALF_W-1:0]   half_a, half_b;
  logic        [ACC_W-1:0]    pp_shifted;
  logic        [SQ_W:0]       esc_sum;
  logic signed [COORD_W-1:0]  cross_term;
  logic signed [COORD_W-1:0]  nr, ni;

  // Add with clamping to the signed range
  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      sat_add = s[COORD_W] ? S_MIN : S_MAX;
    end else begin
      sat_add = s[COORD_W-1:0];
    end
  endfunction

  // Iteration limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITER_RESET;
    end else if (cfg_wr_en) begin
      max_iterations <= cfg_wr_data;
    end
  end

  // Select operands and halves for this partial product
  always_comb begin
    case (cmd.src)
      SRC_IM: begin
        op_a = mag_im;
        op_b = mag_im;
      end
      SRC_X: begin
        op_a = mag_re;
        op_b = mag_im;
      end
      default: begin
        op_a = mag_re;
        op_b = mag_re;
      end
    endcase
    half_a = cmd.pp_idx[1] ? op_a[COORD_W-1:HALF_W] : op_a[HALF_W-1:0];
    half_b = cmd.pp_idx[0] ? op_b[COORD_W-1:HALF_W] : op_b[HALF_W-1:0];
  end

  // Align the registered partial product
  always_comb begin
    case (pp_idx_q) inside
      2'd0:       pp_shifted = {{(ACC_W-2*HALF_W){1'b0}}, pp};
      2'd1, 2'd2: pp_shifted = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
      default:    pp_shifted = {pp, {(ACC_W-2*HALF_W){1'b0}}};
    endcase
  end

  // Form one partial product a cycle
  always_ff @(posedge clk) begin
    pp       <= half_a * half_b;
    pp_idx_q <= cmd.pp_idx;
  end

  // Accumulate, then fix the sign of the cross product
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + pp_shifted;
    end else if (cmd.negate && (zr[COORD_W-1] ^ zi[COORD_W-1])) begin
      acc <= ACC_W'(0) - acc;
    end
  end

  // Escape test on the previous z
  assign esc_sum = {1'b0, re2} + {1'b0, acc[ACC_W-1:FRAC_BITS]};

  // New z: floor(2*zr*zi) from the signed product, both sums saturate
  assign cross_term = acc[FRAC_BITS+COORD_W-2:FRAC_BITS-1];
  assign nr         = sat_add(diff, cr);
  assign ni         = sat_add(cross_term, ci);

  assign status.escape   = esc_sum > ESC_LIMIT;
  assign status.match    = (nr == sr) && (ni == si);
  assign status.at_limit = k == max_iterations;

  // Hold scaled squares and their difference
  always_ff @(posedge clk) begin
    if (cmd.save_re2) begin
      re2 <= acc[ACC_W-1:FRAC_BITS];
    end
    if (cmd.save_im2) begin
      im2 <= acc[FRAC_BITS+COORD_W-1:FRAC_BITS];
    end
    if (cmd.negate) begin
      diff <= re2[COORD_W-1:0] - im2;
    end
  end

  // Magnitudes of z for the unsigned multiplier
  always_ff @(posedge clk) begin
    if (cmd.mag_load) begin
      mag_re <= zr[COORD_W-1] ? COORD_W'(0) - $unsigned(zr) : $unsigned(zr);
      mag_im <= zi[COORD_W-1] ? COORD_W'(0) - $unsigned(zi) : $unsigned(zi);
    end
  end

  // Point, z, saved z and counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr     <= c_re;
      ci     <= c_im;
      zr     <= '0;
      zi     <= '0;
      sr     <= '0;
      si     <= '0;
      k      <= '0;
      period <= '0;
    end else if (cmd.advance) begin
      zr <= nr;
      zi <= ni;
      k  <= k + 1'b1;
      if (period == PERIOD_W'(PERIOD_SPAN)) begin
        period <= '0;
        sr     <= nr;
        si     <= ni;
      end else begin
        period <= period + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_value <= cmd.res_inside ? PIXEL_INSIDE : {1'b0, k[PIXEL_W-2:0]};
    end
  end

endmodule

// File: design/mep_ctrl.sv
// ----------------------------------------------------------------------------
// mep_ctrl: escape-time controller
// Sequences the iteration steps, steps the shared multiplier and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module mep_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 point_valid,
  output logic                 point_ready,
  output logic                 pixel_valid,
  input  logic                 pixel_ready,
  input  mep_pkg::mep_status_t status,
  output mep_pkg::mep_cmd_t    cmd
);
  import mep_pkg::*;

  localparam int                STEP_W   = $clog2(MUL_PARTS + 1);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_PARTS);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_MUL_RE = 9'b000000100,
    S_MUL_IM = 9'b000001000,
    S_TEST   = 9'b000010000,
    S_MUL_X  = 9'b000100000,
    S_NEG    = 9'b001000000,
    S_UPDATE = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t             state, state_next;
  logic [STEP_W-1:0]  step, step_next;
  logic               is_inside, is_inside_next;
  logic               out_valid;
  logic               in_mul;
  logic               mul_last;

  assign in_mul   = (state == S_MUL_RE) || (state == S_MUL_IM) || (state == S_MUL_X);
  assign mul_last = step == MUL_LAST;

  // Next state and commands
  always_comb begin
    state_next     = state;
    is_inside_next = is_inside;
    point_ready    = 1'b0;
    cmd            = '0;
    cmd.src        = SRC_RE;

    // Multiplier steps: clear, then add each partial product in the step after it is formed
    cmd.pp_idx  = step[PP_IDX_W-1:0];
    cmd.acc_clr = in_mul && (step == '0);
    cmd.acc_add = in_mul && (step != '0);
    step_next   = (in_mul && !mul_last) ? step + 1'b1 : '0;

    unique case (state)
      S_IDLE: begin
        point_ready = 1'b1;
        if (point_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.mag_load = 1'b1;
        if (status.at_limit) begin
          is_inside_next = 1'b1;
          state_next     = S_DONE;
        end else begin
          state_next = S_MUL_RE;
        end
      end
      S_MUL_RE: begin
        cmd.src = SRC_RE;
        if (mul_last) begin
          state_next = S_MUL_IM;
        end
      end
      S_MUL_IM: begin
        cmd.src      = SRC_IM;
        cmd.save_re2 = step == '0;
        if (mul_last) begin
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        cmd.save_im2 = 1'b1;
        if (status.escape) begin
          is_inside_next = 1'b0;
          state_next     = S_DONE;
        end else begin
          state_next = S_MUL_X;
        end
      end
      S_MUL_X: begin
        cmd.src = SRC_X;
        if (mul_last) begin
          state_next = S_NEG;
        end
      end
      S_NEG: begin
        cmd.negate = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (status.match) begin
          is_inside_next = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_DONE: begin
        // Wait for a free result register
        if (!out_valid || pixel_ready) begin
          cmd.out_load   = 1'b1;
          cmd.res_inside = is_inside;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, step counter and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      is_inside <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      is_inside <= is_inside_next;
    end
  end

  // Result valid: set on load, drop when the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (pixel_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign pixel_valid = out_valid;

endmodule

// File: design/mandelbrot_escape_time_pixel.sv
// Throughput: one point at a time; the next point is taken the cycle after
// the result is loaded. The iteration time is set by one shared 32x32 multiplier
// forming three 64x64 products of four partial products per iteration.
// Reset (rst, synchronous): idle, no result held, max_iterations = 1024.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel: escape-time count of one complex point
// Iterates z = z*z + c in fixed point and returns the count modulo 128, or
// the inside code for bounded points and points that reach the limit.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel (
  input  logic                             clk,
  input  logic                             rst,
  mep_in_if.sink                           point,
  mep_out_if.source                        pixel,
  input  logic                             cfg_wr_en,
  input  logic [mep_pkg::ITER_W-1:0]       cfg_wr_data
);
  import mep_pkg::*;

  mep_cmd_t    cmd;
  mep_status_t status;

  // Sequencer and handshakes
  mep_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point.valid),
    .point_ready (point.ready),
    .pixel_valid (pixel.valid),
    .pixel_ready (pixel.ready),
    .status      (status),
    .cmd         (cmd)
  );

  // Arithmetic and result register
  mep_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .c_re        (point.c_re),
    .c_im        (point.c_im),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .pixel_value (pixel.pixel_value)
  );

endmodule

// File: design/mep_checker.sv
// ----------------------------------------------------------------------------
// mep_checker: port-level checks of the escape-time pixel
// Watches the point and pixel channels of the top level over time.
// ----------------------------------------------------------------------------
module mep_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        point_valid,
  input logic                        point_ready,
  input logic                        pixel_valid,
  input logic                        pixel_ready,
  input logic [mep_pkg::PIXEL_W-1:0] pixel_value
);
  import mep_pkg::*;

  // Result never exceeds the inside code
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> pixel_value <= PIXEL_INSIDE)
    else $error("pixel value above inside code");

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_value))
    else $error("stalled result changed");

  // One point in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_ready |=> !point_ready)
    else $error("point taken while busy");

  // Reset leaves the block idle with no result
  a_reset_idle: assert property (@(posedge clk)
    rst |=> point_ready && !pixel_valid)
    else $error("not idle after reset");

endmodule

bind mandelbrot_escape_time_pixel mep_checker u_mep_checker (
  .clk         (clk),
  .rst         (rst),
  .point_valid (point.valid),
  .point_ready (point.ready),
  .pixel_valid (pixel.valid),
  .pixel_ready (pixel.ready),
  .pixel_value (pixel.pixel_value)
);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the escape-time pixel
// Drives complex points into the point channel, predicts each pixel with an
// independent fixed-point iteration in the testbench and checks every pixel
// in order. Directed points cover the reset limit, zero and single-iteration
// limits, the widest limit, exact escape-radius hits, cycle detection and
// extreme coordinates; random traffic then runs under changing limits with
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import mep_pkg::*;

  // Timing figures that size the watchdog budget, and run sizes
  localparam int CYCLES_PER_ITER = 19;
  localparam int ESCAPE_CYCLES   = 13;
  localparam int LIMIT_MARGIN    = 4;
  localparam int SLACK_CYCLES    = 500;
  localparam int TAIL_CYCLES     = 40;
  localparam int MAX_REPORTS     = 10;
  localparam int BLOCK_ITEMS     = 28;
  localparam int BLOCKS_PER_MODE = 4;

  // Handy fixed-point values
  localparam logic signed [COORD_W-1:0] FX_ONE    = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct {
    logic [PIXEL_W-1:0]        pixel;
    logic signed [COORD_W-1:0] c_re;
    logic signed [COORD_W-1:0] c_im;
    logic [ITER_W-1:0]         limit;
  } pixel_entry_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [ITER_W-1:0] cfg_wr_data;

  mep_in_if  point_ch ();
  mep_out_if pixel_ch ();

  mandelbrot_escape_time_pixel u_dut (
    .clk         (clk),
    .rst         (rst),
    .point       (point_ch),
    .pixel       (pixel_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  pixel_entry_t      pending_pixels[$];
  logic [ITER_W-1:0] iter_limit;
  int                idle_pct;
  int                stall_pct;
  int                mismatch_count;
  int                unexpected_count;
  int                inside_count;
  int                escaped_count;
  int                points_sent;
  int                limits_used;
  longint unsigned   cycle_count;
  longint unsigned   cycle_limit;

  // Free-running clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturate a wide sum into the coordinate range
  function automatic logic signed [COORD_W-1:0] clamp_coord(input logic signed [ACC_W+1:0] v);
    logic signed [ACC_W+1:0] hi_lim;
    logic signed [ACC_W+1:0] lo_lim;
    hi_lim = COORD_MAX;
    lo_lim = COORD_MIN;
    if (v > hi_lim) return COORD_MAX;
    if (v < lo_lim) return COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  // Escape-time pixel of one point under the given limit
  function automatic logic [PIXEL_W-1:0] escape_pixel(input logic signed [COORD_W-1:0] cr,
                                                     input logic signed [COORD_W-1:0] ci,
                                                     input logic [ITER_W-1:0] lim);
    logic signed [COORD_W-1:0] zr, zi, sr, si, nr, ni;
    logic signed [ACC_W+1:0]   wr, wi, re2, im2, xprod, radius_sq;
    int unsigned               k, phase;
    bit                        bounded;
    zr = '0;
    zi = '0;
    sr = '0;
    si = '0;
    k = 0;
    phase = 0;
    bounded = 1'b0;
    radius_sq = ESC_RADIUS_SQ;
    radius_sq = radius_sq <<< FRAC_BITS;
    while (k < lim) begin
      wr = zr;
      wi = zi;
      re2 = (wr * wr) >>> FRAC_BITS;
      im2 = (wi * wi) >>> FRAC_BITS;
      // escape test on the current z
      if (re2 + im2 > radius_sq) break;
      xprod = (wr * wi) <<< 1;
      xprod = xprod >>> FRAC_BITS;
      nr = clamp_coord(re2 - im2 + cr);
      ni = clamp_coord(xprod + ci);
      // exact return to the saved z means a cycle
      if (nr == sr && ni == si) begin
        bounded = 1'b1;
        break;
      end
      k++;
      if (phase == PERIOD_SPAN) begin
        phase = 0;
        sr = nr;
        si = ni;
      end else begin
        phase++;
      end
      zr = nr;
      zi = ni;
    end
    if (bounded || k == lim) return PIXEL_INSIDE;
    return PIXEL_W'(k[6:0]);
  endfunction

  // Uniform coordinate in [lo, hi), bounds in units of 1/256
  function automatic logic signed [COORD_W-1:0] rand_coord(input int lo_q8, input int hi_q8);
    logic [COORD_W-1:0] span;
    logic [COORD_W-1:0] offs;
    span = COORD_W'(hi_q8 - lo_q8) << (FRAC_BITS - 8);
    offs = {$urandom, $urandom} % span;
    return (COORD_W'(lo_q8) << (FRAC_BITS - 8)) + offs;
  endfunction

  // Send one point, record its predicted pixel and widen the run budget
  task automatic send_point(input logic signed [COORD_W-1:0] cr,
                            input logic signed [COORD_W-1:0] ci);
    pixel_entry_t entry;
    while ($urandom_range(0, 99) < idle_pct) begin
      point_ch.valid <= 1'b0;
      @(posedge clk);
    end
    point_ch.valid <= 1'b1;
    point_ch.c_re  <= cr;
    point_ch.c_im  <= ci;
    do @(posedge clk); while (!point_ch.ready);
    entry.pixel = escape_pixel(cr, ci, iter_limit);
    entry.c_re  = cr;
    entry.c_im  = ci;
    entry.limit = iter_limit;
    pending_pixels.push_back(entry);
    points_sent++;
    cycle_limit += LIMIT_MARGIN * (CYCLES_PER_ITER * (longint'(iter_limit) + 1) + ESCAPE_CYCLES)
                   + SLACK_CYCLES;
  endtask

  // Drop valid and hold until every pixel sent so far has come back
  task automatic wait_all_pixels();
    point_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  // Write the iteration limit; the block must be idle
  task automatic set_iteration_limit(input logic [ITER_W-1:0] lim);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    iter_limit = lim;
    limits_used++;
  endtask

  // Limit for a block of random points: mostly short, sometimes long
  function automatic logic [ITER_W-1:0] draw_iteration_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return ITER_W'($urandom_range(1, 40));
    if (r < 85) return ITER_W'($urandom_range(41, 300));
    if (r < 95) return ITER_W'($urandom_range(0, 2));
    return MAX_ITER_RESET;
  endfunction

  // Reset limit: cycle detection, radius hits, limit reached, extremes
  task automatic test_reset_limit();
    send_point('0, '0);
    send_point(-FX_ONE, '0);
    send_point(-2 * FX_ONE, '0);
    send_point(2 * FX_ONE, '0);
    send_point('0, FX_ONE);
    send_point(FX_ONE >>> 2, '0);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MIN);
    wait_all_pixels();
  endtask

  // Zero limit, one and two iterations, widest limit
  task automatic test_limit_extremes();
    set_iteration_limit('0);
    send_point(FX_ONE >>> 1, FX_ONE >>> 1);
    send_point(COORD_MIN, COORD_MAX);
    wait_all_pixels();
    set_iteration_limit(ITER_W'(1));
    send_point('0, '0);
    send_point(3 * FX_ONE, '0);
    send_point(FX_ONE >>> 1, '0);
    wait_all_pixels();
    set_iteration_limit(ITER_W'(2));
    send_point(3 * FX_ONE, '0);
    send_point('0, -3 * FX_ONE);
    wait_all_pixels();
    set_iteration_limit('1);
    send_point('0, '0);
    send_point(-FX_ONE, '0);
    send_point(-2 * FX_ONE, '0);
    send_point(COORD_MAX, '0);
    wait_all_pixels();
  endtask

  // Escape counts past 127 near the cusp
  task automatic test_count_wrap();
    set_iteration_limit(MAX_ITER_RESET);
    send_point((FX_ONE >>> 2) + (FX_ONE >>> 12), '0);
    send_point((FX_ONE >>> 2) + (FX_ONE >>> 10), FX_ONE >>> 20);
    wait_all_pixels();
  endtask

  // Random points in blocks of one limit each, over all idling modes
  task automatic test_random_traffic();
    logic signed [COORD_W-1:0] cr, ci;
    int r;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int blk = 0; blk < BLOCKS_PER_MODE; blk++) begin
        set_iteration_limit(draw_iteration_limit());
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          r = $urandom_range(0, 99);
          if (r < 65) begin
            cr = rand_coord(-576, 192);
            ci = rand_coord(-384, 384);
          end else if (r < 75) begin
            cr = (longint'($urandom_range(0, 40)) - 20) <<< (FRAC_BITS - 3);
            ci = (longint'($urandom_range(0, 40)) - 20) <<< (FRAC_BITS - 3);
          end else if (r < 83) begin
            cr = (FX_ONE >>> 2) + ({$urandom, $urandom} % (64'd1 << (FRAC_BITS - 10)));
            ci = rand_coord(-1, 1);
          end else begin
            cr = {$urandom, $urandom};
            ci = {$urandom, $urandom};
          end
          // hold off now and then until the block has drained
          if ((mode == 0 && blk == 0 && n == BLOCK_ITEMS / 2) || $urandom_range(0, 39) == 0)
            wait_all_pixels();
          send_point(cr, ci);
        end
        wait_all_pixels();
      end
    end
  endtask

  // Receiver: stall at the rate of the current mode
  always @(posedge clk) begin
    pixel_ch.ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
  end

  // Compare each pixel with the oldest prediction
  always @(posedge clk) begin
    pixel_entry_t head;
    if (!rst && pixel_ch.valid && pixel_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        unexpected_count++;
        if (mismatch_count + unexpected_count <= MAX_REPORTS)
          $display("ERROR: pixel %0d with no point outstanding", pixel_ch.pixel_value);
      end else begin
        head = pending_pixels.pop_front();
        if (pixel_ch.pixel_value !== head.pixel) begin
          mismatch_count++;
          if (mismatch_count + unexpected_count <= MAX_REPORTS)
            $display("ERROR: c=(%h, %h) limit %0d: pixel expected %0d, got %0d",
                     head.c_re, head.c_im, head.limit, head.pixel, pixel_ch.pixel_value);
        end
        if (head.pixel == PIXEL_INSIDE) inside_count++;
        else escaped_count++;
      end
    end
  end

  // Watchdog against a budget that grows with every point sent
  initial begin
    cycle_count = 0;
    cycle_limit = 200000;
    while (cycle_count <= cycle_limit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: timeout after %0d cycles", cycle_count);
    $display("simulation failed");
    $finish;
  end

  // Main sequence
  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    point_ch.valid   = 1'b0;
    point_ch.c_re    = '0;
    point_ch.c_im    = '0;
    iter_limit       = MAX_ITER_RESET;
    idle_pct         = 16;
    stall_pct        = 16;
    mismatch_count   = 0;
    unexpected_count = 0;
    inside_count     = 0;
    escaped_count    = 0;
    points_sent      = 0;
    limits_used      = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_limit();
    test_limit_extremes();
    test_count_wrap();
    test_random_traffic();

    // let any stray pixel show up
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d points checked under %0d limit settings: %0d inside, %0d escaped",
             points_sent, limits_used, inside_count, escaped_count);
    $display("%0d mismatches, %0d unexpected pixels, %0d points left without a pixel",
             mismatch_count, unexpected_count, pending_pixels.size());
    if (mismatch_count == 0 && unexpected_count == 0 && pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
